>>> rtl/gpx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpx_pkg;

  localparam int unsigned PORT_W          = 8;
  localparam int unsigned PIN_COUNT_DEF   = 8;

  // item modes
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RO      = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  // register command bytes
  localparam logic [7:0] ADDR_INPUT     = 8'h00;
  localparam logic [7:0] ADDR_OUTPUT    = 8'h01;
  localparam logic [7:0] ADDR_POLARITY  = 8'h02;
  localparam logic [7:0] ADDR_DIRECTION = 8'h03;
  localparam logic [7:0] ADDR_STR_LO    = 8'h40;
  localparam logic [7:0] ADDR_STR_HI    = 8'h41;
  localparam logic [7:0] ADDR_LATCH     = 8'h42;
  localparam logic [7:0] ADDR_PULL_EN   = 8'h43;
  localparam logic [7:0] ADDR_PULL_SEL  = 8'h44;
  localparam logic [7:0] ADDR_IRQ_MASK  = 8'h45;
  localparam logic [7:0] ADDR_IRQ_STAT  = 8'h46;
  localparam logic [7:0] ADDR_OUT_CFG   = 8'h4F;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] pin_levels;
  } gpx_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  status;
    logic [7:0]  drive_value;
    logic [7:0]  drive_enable;
    logic [7:0]  pull_enable_out;
    logic [7:0]  pull_up_out;
    logic [15:0] drive_strength_out;
    logic        open_drain_out;
    logic        irq_active;
  } gpx_out_t;

  typedef struct packed {
    logic [7:0]  out_port;
    logic [7:0]  polarity;
    logic [7:0]  direction;
    logic [15:0] strength;
    logic [7:0]  latch_en;
    logic [7:0]  pull_en;
    logic [7:0]  pull_sel;
    logic [7:0]  irq_mask;
    logic        open_drain;
  } gpx_cfg_t;

  // per-pin view handed to a lane
  typedef struct packed {
    logic pin;
    logic pol;
    logic dir;
    logic latch;
    logic mask;
    logic stat;
    logic inval;
    logic refv;
  } gpx_lane_in_t;

  typedef struct packed {
    logic inval;
    logic stat;
  } gpx_lane_out_t;

endpackage

`default_nettype wire

>>> rtl/gpio_expander_register_block.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | signals                          | payload
// --------+----------------------------------+-----------
// in      | in_valid_i / in_ready_o          | gpx_in_t
// out     | out_valid_o / out_ready_i        | gpx_out_t
//
// One item per clock: the register update and all pin lanes settle in the
// accept cycle and the result is captured in the output register at its end.
// A waiting result stalls input only when out_ready_i is low.
// Reset loads the register defaults and clears input value, status and the
// reference snapshot; no clearing pass.

module gpio_expander_register_block
  import gpx_pkg::*;
#(
  parameter int unsigned PIN_COUNT = PIN_COUNT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gpx_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gpx_out_t out_item_o
);

  localparam logic [PORT_W-1:0] PinMask = PORT_W'((1 << PIN_COUNT) - 1);

  logic in_fire;
  logic is_read;
  logic is_write;
  logic is_sample;

  gpx_cfg_t   cfg_q;
  gpx_cfg_t   cfg_d;
  logic [1:0] wr_status;

  logic [PORT_W-1:0] inval_q, inval_d;
  logic [PORT_W-1:0] stat_q,  stat_d;
  logic [PORT_W-1:0] ref_q,   ref_d;
  logic [PORT_W-1:0] lane_inval;
  logic [PORT_W-1:0] lane_stat;

  logic [7:0] rd_data;
  logic [1:0] rd_status;

  logic     out_valid_q;
  gpx_out_t out_q, out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_read    = in_item_i.mode == MODE_READ;
  assign is_write   = in_item_i.mode == MODE_WRITE;
  assign is_sample  = in_item_i.mode == MODE_SAMPLE;

  gpx_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (in_fire && is_write),
    .addr_i      (in_item_i.reg_addr),
    .data_i      (in_item_i.write_data),
    .cfg_q_o     (cfg_q),
    .cfg_d_o     (cfg_d),
    .wr_status_o (wr_status)
  );

  // one lane per pin; pins past PIN_COUNT stay at zero
  for (genvar p = 0; p < PORT_W; p++) begin : g_lane
    if (p < PIN_COUNT) begin : g_on
      gpx_lane_in_t  lin;
      gpx_lane_out_t lout;
      assign lin.pin   = in_item_i.pin_levels[p];
      assign lin.pol   = cfg_q.polarity[p];
      assign lin.dir   = cfg_q.direction[p];
      assign lin.latch = cfg_q.latch_en[p];
      assign lin.mask  = cfg_q.irq_mask[p];
      assign lin.stat  = stat_q[p];
      assign lin.inval = inval_q[p];
      assign lin.refv  = ref_q[p];
      gpx_pin_lane u_lane (
        .lane_i (lin),
        .lane_o (lout)
      );
      assign lane_inval[p] = lout.inval;
      assign lane_stat[p]  = lout.stat;
    end else begin : g_off
      assign lane_inval[p] = 1'b0;
      assign lane_stat[p]  = 1'b0;
    end
  end

  always_comb begin
    rd_data   = 8'h00;
    rd_status = ST_OK;
    case (in_item_i.reg_addr)
      ADDR_INPUT:     rd_data = inval_q;
      ADDR_OUTPUT:    rd_data = cfg_q.out_port;
      ADDR_POLARITY:  rd_data = cfg_q.polarity;
      ADDR_DIRECTION: rd_data = cfg_q.direction;
      ADDR_STR_LO:    rd_data = cfg_q.strength[7:0];
      ADDR_STR_HI:    rd_data = cfg_q.strength[15:8];
      ADDR_LATCH:     rd_data = cfg_q.latch_en;
      ADDR_PULL_EN:   rd_data = cfg_q.pull_en;
      ADDR_PULL_SEL:  rd_data = cfg_q.pull_sel;
      ADDR_IRQ_MASK:  rd_data = cfg_q.irq_mask;
      ADDR_IRQ_STAT:  rd_data = stat_q;
      ADDR_OUT_CFG:   rd_data = {7'b0, cfg_q.open_drain};
      default:        rd_status = ST_UNKNOWN;
    endcase
  end

  // merge: lane results and input-port read side effects
  always_comb begin
    inval_d = inval_q;
    stat_d  = stat_q;
    ref_d   = ref_q;
    if (in_fire) begin
      if (is_sample) begin
        inval_d = lane_inval;
        stat_d  = lane_stat;
      end else if (is_read && in_item_i.reg_addr == ADDR_INPUT) begin
        ref_d  = inval_q;
        stat_d = '0;
      end
    end
  end

  always_comb begin
    out_d.read_data          = is_read ? rd_data : 8'h00;
    out_d.status             = is_read ? rd_status : (is_write ? wr_status : ST_OK);
    out_d.drive_value        = cfg_d.out_port;
    out_d.drive_enable       = ~cfg_d.direction & PinMask;
    out_d.pull_enable_out    = cfg_d.pull_en;
    out_d.pull_up_out        = cfg_d.pull_sel;
    out_d.drive_strength_out = cfg_d.strength;
    out_d.open_drain_out     = cfg_d.open_drain;
    out_d.irq_active         = |stat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inval_q     <= '0;
      stat_q      <= '0;
      ref_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      inval_q <= inval_d;
      stat_q  <= stat_d;
      ref_q   <= ref_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // input-port read clears every status bit
  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_read && in_item_i.reg_addr == ADDR_INPUT
    |=> stat_q == '0 && !out_item_o.irq_active)
    else $error("status not cleared by input port read");

  // pins outside the configured count never raise status or input value
  a_pin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_q & ~PinMask) == '0 && (inval_q & ~PinMask) == '0)
    else $error("state set on unused pin");

  // writes to read-only registers are flagged
  a_ro_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_write &&
    (in_item_i.reg_addr == ADDR_INPUT || in_item_i.reg_addr == ADDR_IRQ_STAT)
    |=> out_item_o.status == ST_RO)
    else $error("read-only write not flagged");

  // interrupt line in a result follows the status register
  a_irq_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_item_o.irq_active == (|stat_q))
    else $error("irq_active does not match status");

endmodule

`default_nettype wire

>>> rtl/gpx_pin_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module gpx_pin_lane
  import gpx_pkg::*;
(
  input  gpx_lane_in_t  lane_i,
  output gpx_lane_out_t lane_o
);

  logic level;
  logic hold;
  logic change;

  always_comb begin
    level  = lane_i.pin ^ (lane_i.pol & lane_i.dir);
    // latched input with a pending event keeps its captured value
    hold   = lane_i.stat & lane_i.latch & lane_i.dir;
    change = (level ^ lane_i.refv) & lane_i.dir & ~lane_i.mask;
    lane_o.inval = hold ? lane_i.inval : level;
    lane_o.stat  = (lane_i.stat & lane_i.latch) | change;
  end

endmodule

`default_nettype wire

>>> rtl/gpx_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module gpx_regs
  import gpx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [7:0] addr_i,
  input  logic [7:0] data_i,
  output gpx_cfg_t   cfg_q_o,
  output gpx_cfg_t   cfg_d_o,
  output logic [1:0] wr_status_o
);

  gpx_cfg_t cfg_q;
  gpx_cfg_t cfg_d;
  logic [1:0] wr_status;

  always_comb begin
    cfg_d     = cfg_q;
    wr_status = ST_OK;
    case (addr_i)
      ADDR_INPUT, ADDR_IRQ_STAT: wr_status = ST_RO;
      ADDR_OUTPUT:    cfg_d.out_port       = data_i;
      ADDR_POLARITY:  cfg_d.polarity       = data_i;
      ADDR_DIRECTION: cfg_d.direction      = data_i;
      ADDR_STR_LO:    cfg_d.strength[7:0]  = data_i;
      ADDR_STR_HI:    cfg_d.strength[15:8] = data_i;
      ADDR_LATCH:     cfg_d.latch_en       = data_i;
      ADDR_PULL_EN:   cfg_d.pull_en        = data_i;
      ADDR_PULL_SEL:  cfg_d.pull_sel       = data_i;
      ADDR_IRQ_MASK:  cfg_d.irq_mask       = data_i;
      ADDR_OUT_CFG:   cfg_d.open_drain     = data_i[0];
      default:        wr_status = ST_UNKNOWN;
    endcase
    if (!wr_en_i) begin
      cfg_d = cfg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_port   <= 8'hFF;
      cfg_q.polarity   <= 8'h00;
      cfg_q.direction  <= 8'hFF;
      cfg_q.strength   <= 16'hFFFF;
      cfg_q.latch_en   <= 8'h00;
      cfg_q.pull_en    <= 8'h00;
      cfg_q.pull_sel   <= 8'hFF;
      cfg_q.irq_mask   <= 8'hFF;
      cfg_q.open_drain <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_q_o     = cfg_q;
  assign cfg_d_o     = cfg_d;
  assign wr_status_o = wr_status;

endmodule

`default_nettype wire
